// ===== hdl/sfr_pkg.sv =====
// sfr_pkg: shared types, codes and defaults for the sensor frame receiver.
// Used by sfr_ctrl, sfr_datapath and sensor_frame_receiver_top; no dependencies.
package sfr_pkg;

   localparam int PAYLOAD_MAX_DEF = 32;
   localparam int FRAME_MAX_DEF   = 37;
   localparam int MAX_READINGS    = 16;
   localparam int IDX_W           = 4;

   localparam logic [7:0] START_MARKER_RST = 8'hAA;
   localparam logic [7:0] END_MARKER_RST   = 8'hBB;
   localparam logic [7:0] EXP_CMD_RST      = 8'h0C;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_START_MARKER = 2'd0;
   localparam logic [1:0] REG_END_MARKER   = 2'd1;
   localparam logic [1:0] REG_EXP_CMD      = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_READING = 2'd0;
   localparam status_type ST_EMPTY   = 2'd1;
   localparam status_type ST_BAD_SUM = 2'd2;
   localparam status_type ST_BAD_CMD = 2'd3;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] expected_command;
   } cfg_type;

   typedef struct packed {
      logic accept;        // byte request taken this cycle
      logic rd_hi;         // read high byte of current reading
      logic rd_lo;         // read low byte of current reading
      logic cap_hi;        // latch high byte from read data
      logic load_status;   // load single status result
      logic load_reading;  // load one reading result
      logic idx_inc;       // advance to next reading
   } dp_cmd_type;

   typedef struct packed {
      logic done;          // accepted byte closes a complete frame
      logic has_reads;     // that frame yields readings
      logic last_reading;  // current reading is the final one shown
   } dp_stat_type;

endpackage

// ===== hdl/sfr_ctrl.sv =====
// sfr_ctrl: controller FSM for the sensor frame receiver.
// Sequences byte intake and result drain; depends on sfr_pkg.
module sfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  sfr_pkg::dp_stat_type stat,
   output sfr_pkg::dp_cmd_type  cmd
);
   import sfr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STATUS,
      S_RD_HI,
      S_RD_LO,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      valid_in = (valid_ff && !rsp_tready);
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid && stat.done) begin
               state_in = stat.has_reads ? S_RD_HI : S_STATUS;
            end
         end
         S_STATUS: begin
            if (out_free) begin
               cmd.load_status = 1'b1;
               valid_in        = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = S_RD_LO;
         end
         S_RD_LO: begin
            cmd.rd_lo  = 1'b1;
            cmd.cap_hi = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_reading = 1'b1;
               valid_in         = 1'b1;
               if (stat.last_reading) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_RD_HI;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hdl/sfr_datapath.sv =====
// sfr_datapath: frame store, byte counter, checksum and result register.
// Driven by sfr_ctrl commands; depends on sfr_pkg.
module sfr_datapath #(
   parameter int PAYLOAD_MAX = sfr_pkg::PAYLOAD_MAX_DEF,
   parameter int FRAME_MAX   = sfr_pkg::FRAME_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sfr_pkg::cfg_type          cfg,
   input  logic [7:0]                req_byte,
   input  sfr_pkg::dp_cmd_type       cmd,
   output sfr_pkg::dp_stat_type      stat,
   output sfr_pkg::status_type       out_status,
   output logic [sfr_pkg::IDX_W-1:0] out_index,
   output logic [15:0]               out_temp,
   output logic [4:0]                out_count,
   output logic                      out_last
);
   import sfr_pkg::*;

   localparam int CW = $clog2(FRAME_MAX + 1);
   localparam int AW = $clog2(FRAME_MAX);

   logic [7:0]       store_mem [FRAME_MAX];
   logic [7:0]       rd_data_ff;

   logic [CW-1:0]    count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       len_ff, cmd_ff, prev_ff, hi_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [6:0]       n_ff;
   status_type       fin_code_ff, fin_code;

   logic [8:0]       pos9, cnt9, rd_addr9;
   logic [7:0]       len_eff, sum_base, sum_new;
   logic             stored, too_long, full, done;
   logic [IDX_W-1:0] shown_last;

   always_comb begin
      pos9     = 9'(count_ff);
      cnt9     = pos9 + 9'd1;
      stored   = cmd.accept && !(count_ff == '0 && req_byte != cfg.start_marker);
      len_eff  = (pos9 == 9'd2) ? req_byte : len_ff;
      sum_base = (count_ff == '0) ? 8'd0 : sum_ff;
      // start, command, length and payload bytes feed the checksum
      if (pos9 < 9'd3 || pos9 < 9'd3 + 9'(len_eff)) begin
         sum_new = sum_base + req_byte;
      end else begin
         sum_new = sum_base;
      end
      too_long = (pos9 == 9'd2) && (9'(len_eff) > 9'(PAYLOAD_MAX));
      full     = (cnt9 >= 9'(FRAME_MAX));
      done     = stored && (cnt9 >= 9'd5)
                 && (9'd4 + 9'(len_eff) < 9'(FRAME_MAX))
                 && (cnt9 == 9'd5 + 9'(len_eff))
                 && (req_byte == cfg.end_marker);
      // checksum byte is the one just before the end marker
      if (prev_ff != sum_new) begin
         fin_code = ST_BAD_SUM;
      end else if (cmd_ff != cfg.expected_command) begin
         fin_code = ST_BAD_CMD;
      end else if (len_eff[7:1] == 7'd0) begin
         fin_code = ST_EMPTY;
      end else begin
         fin_code = ST_READING;
      end
      if (stored && (too_long || done || full)) begin
         count_in = '0;
         sum_in   = 8'd0;
      end else if (stored) begin
         count_in = cnt9[CW-1:0];
         sum_in   = sum_new;
      end else begin
         count_in = count_ff;
         sum_in   = sum_ff;
      end
      if (n_ff > 7'(MAX_READINGS)) begin
         shown_last = IDX_W'(MAX_READINGS - 1);
      end else begin
         shown_last = IDX_W'(n_ff - 7'd1);
      end
      rd_addr9 = (cmd.rd_lo ? 9'd4 : 9'd3) + {4'd0, idx_ff, 1'b0};
   end

   assign stat.done         = done;
   assign stat.has_reads    = (fin_code == ST_READING);
   assign stat.last_reading = (idx_ff == shown_last);

   always_ff @(posedge clock) begin
      if (stored) begin
         store_mem[pos9[AW-1:0]] <= req_byte;
      end
      if (cmd.rd_hi || cmd.rd_lo) begin
         rd_data_ff <= store_mem[rd_addr9[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= 8'd0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         if (done) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stored) begin
         prev_ff <= req_byte;
         if (pos9 == 9'd1) begin
            cmd_ff <= req_byte;
         end
         if (pos9 == 9'd2) begin
            len_ff <= req_byte;
         end
      end
      if (done) begin
         fin_code_ff <= fin_code;
         n_ff        <= len_eff[7:1];
      end
      if (cmd.cap_hi) begin
         hi_ff <= rd_data_ff;
      end
      if (cmd.load_status) begin
         out_status <= fin_code_ff;
         out_index  <= '0;
         out_temp   <= 16'd0;
         out_count  <= 5'd0;
         out_last   <= 1'b1;
      end else if (cmd.load_reading) begin
         out_status <= ST_READING;
         out_index  <= idx_ff;
         out_temp   <= {hi_ff, rd_data_ff};
         out_count  <= n_ff[4:0];
         out_last   <= (idx_ff == shown_last);
      end
   end

endmodule

// ===== hdl/sensor_frame_receiver_top.sv =====
// Sensor frame receiver: takes one byte request per cycle while hunting or storing.
// A bad length, wrong end byte or full store drops the frame silently. After the end
// byte requests are held while a status result, or each reading through read-high,
// read-low and emit steps, loads when the output frees; two reads per reading use
// the single registered read port of the store. Synchronous active-high reset clears
// the counters, handshake state and restores register defaults; the store needs none.
module sensor_frame_receiver_top #(
   parameter int PAYLOAD_MAX = sfr_pkg::PAYLOAD_MAX_DEF,
   parameter int FRAME_MAX   = sfr_pkg::FRAME_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] sensor_index, [19:4] temperature_tenths,
                                    // [24:20] reading_count, [31:25] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sfr_pkg::*;

   cfg_type             cfg_ff;
   dp_cmd_type          cmd;
   dp_stat_type         stat;
   status_type          out_status;
   logic [IDX_W-1:0]    out_index;
   logic [15:0]         out_temp;
   logic [4:0]          out_count;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker     <= START_MARKER_RST;
         cfg_ff.end_marker       <= END_MARKER_RST;
         cfg_ff.expected_command <= EXP_CMD_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_START_MARKER: cfg_ff.start_marker     <= csr_pwdata[7:0];
            REG_END_MARKER:   cfg_ff.end_marker       <= csr_pwdata[7:0];
            REG_EXP_CMD:      cfg_ff.expected_command <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_START_MARKER: csr_prdata = {24'd0, cfg_ff.start_marker};
         REG_END_MARKER:   csr_prdata = {24'd0, cfg_ff.end_marker};
         REG_EXP_CMD:      csr_prdata = {24'd0, cfg_ff.expected_command};
         default:          csr_prdata = 32'd0;
      endcase
   end

   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfr_datapath #(
      .PAYLOAD_MAX (PAYLOAD_MAX),
      .FRAME_MAX   (FRAME_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_byte   (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .out_status (out_status),
      .out_index  (out_index),
      .out_temp   (out_temp),
      .out_count  (out_count),
      .out_last   (rsp_tlast)
   );

   assign rsp_tuser = out_status;
   assign rsp_tdata = {7'd0, out_count, out_temp, out_index};

   // status results stand alone
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_READING) |-> rsp_tlast)
      else $error("status result without last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_READING) |-> (rsp_tdata == 32'd0))
      else $error("status result carries reading data");

   // while a frame still drains, no new byte request is taken
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |-> !req_tready)
      else $error("byte request taken during drain");

endmodule
